// ===== src/descending_argsort_defines.svh =====
// Assertion macros used by the descending argsort top level.
`ifndef DESCENDING_ARGSORT_DEFINES_SVH
`define DESCENDING_ARGSORT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dsa_pkg.sv =====
// Package with the transfer types and control struct of the descending argsort.
`timescale 1ns / 1ps
`default_nettype none

package dsa_pkg;

    // Fixed widths of the transfer fields.
    localparam int VALUE_IN_BITS = 32;
    localparam int POSITION_BITS = 7;

    // One input transfer.
    typedef struct packed {
        logic [VALUE_IN_BITS-1:0] value;
        logic                     last_in;
    } in_item_t;

    // One result transfer.
    typedef struct packed {
        logic [POSITION_BITS-1:0] position;
        logic                     last_out;
        logic                     overflow;
    } out_item_t;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic load;
        logic drain;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/dsa_cell.sv =====
// One cell of the insertion chain: holds a single (value, position) pair.
`timescale 1ns / 1ps
`default_nettype none

module dsa_cell #(
    parameter int VALUE_BITS = 32,
    parameter int IDX_BITS   = 6
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  dsa_pkg::cell_ctrl_t   ctrl,
    // Element being inserted, broadcast to all cells.
    input  wire  [VALUE_BITS-1:0] new_value,
    input  wire  [IDX_BITS-1:0]   new_index,
    // Neighbour towards the head of the chain.
    input  wire                   prev_valid,
    input  wire  [VALUE_BITS-1:0] prev_value,
    input  wire  [IDX_BITS-1:0]   prev_index,
    input  wire                   prev_ins,
    // Neighbour towards the tail of the chain.
    input  wire                   next_valid,
    input  wire  [VALUE_BITS-1:0] next_value,
    input  wire  [IDX_BITS-1:0]   next_index,
    // Own contents and insertion decision.
    output logic                  valid,
    output logic [VALUE_BITS-1:0] value,
    output logic [IDX_BITS-1:0]   index,
    output logic                  ins
);

    logic                  valid_reg, valid_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [IDX_BITS-1:0]   index_reg, index_next;

    // The new element always carries the highest position so far, so a tie
    // ranks it first; an empty cell always accepts.
    assign ins = !valid_reg || (new_value >= value_reg);

    // Load shifts the tail down behind the insertion point; drain shifts up.
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        index_next = index_reg;
        if (ctrl.drain)
        begin
            valid_next = next_valid;
            value_next = next_value;
            index_next = next_index;
        end
        else if (ctrl.load)
        begin
            if (prev_ins)
            begin
                valid_next = prev_valid;
                value_next = prev_value;
                index_next = prev_index;
            end
            else if (ins)
            begin
                valid_next = 1'b1;
                value_next = new_value;
                index_next = new_index;
            end
        end
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        index_reg <= index_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign index = index_reg;

endmodule

`default_nettype wire

// ===== src/descending_argsort.sv =====
// Top level of the descending argsort: sequencer and chain of insertion cells.
//
//  Channel | Ports                      | Transfer
//  --------+----------------------------+--------------------------------------
//  input   | start, busy, item          | at a rising edge with start && !busy
//  result  | result_valid, result       | at a rising edge with result_valid, no back-pressure
//
// A load transfer is inserted into the chain at the edge that takes it, so loads may follow
// back to back. The closing transfer starts the drain: busy rises and the stored values
// come out as results in ranked order, one cell shift each. Reset (rst_n low) empties the
// chain and clears the count and overflow flag. The receiver cannot stall; only busy holds
// off new input during a drain.
`timescale 1ns / 1ps
`default_nettype none
`include "descending_argsort_defines.svh"

module descending_argsort #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  dsa_pkg::in_item_t   item,
    output logic                result_valid,
    output dsa_pkg::out_item_t  result
);

    localparam int IDX_BITS = $clog2(MAX_ITEMS);
    localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);
    localparam int PB       = dsa_pkg::POSITION_BITS;

    // Sequencer states.
    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                overflow_reg, overflow_next;

    logic                accept;
    logic                full;
    logic                last_result;
    dsa_pkg::cell_ctrl_t ctrl;
    logic [VALUE_BITS-1:0] new_value;
    logic [IDX_BITS-1:0]   new_index;

    logic                  cell_valid [MAX_ITEMS];
    logic [VALUE_BITS-1:0] cell_value [MAX_ITEMS];
    logic [IDX_BITS-1:0]   cell_index [MAX_ITEMS];
    logic                  cell_ins   [MAX_ITEMS];

    // Input transfer and capacity.
    assign busy      = (state_reg == ST_DRAIN);
    assign accept    = start && !busy;
    assign full      = (count_reg == CNT_BITS'(MAX_ITEMS));
    assign new_value = VALUE_BITS'(item.value);
    assign new_index = count_reg[IDX_BITS-1:0];

    assign ctrl.load  = accept && !full;
    assign ctrl.drain = busy;

    // The final result is the one whose successor cell is empty.
    assign last_result = !cell_valid[1];

    // Sequencer: load until the closing transfer, then drain the chain.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_BITS'(1);
                    end
                    if (item.last_in)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (last_result)
                begin
                    state_next    = ST_LOAD;
                    count_next    = '0;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // Chain of cells, head at index 0.
    for (genvar k = 0; k < MAX_ITEMS; k++)
    begin : g_cell
        logic                  p_valid;
        logic [VALUE_BITS-1:0] p_value;
        logic [IDX_BITS-1:0]   p_index;
        logic                  p_ins;
        logic                  n_valid;
        logic [VALUE_BITS-1:0] n_value;
        logic [IDX_BITS-1:0]   n_index;

        if (k == 0)
        begin : g_head
            assign p_valid = 1'b0;
            assign p_value = '0;
            assign p_index = '0;
            assign p_ins   = 1'b0;
        end
        else
        begin : g_body
            assign p_valid = cell_valid[k-1];
            assign p_value = cell_value[k-1];
            assign p_index = cell_index[k-1];
            assign p_ins   = cell_ins[k-1];
        end

        if (k == MAX_ITEMS - 1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_value = '0;
            assign n_index = '0;
        end
        else
        begin : g_inner
            assign n_valid = cell_valid[k+1];
            assign n_value = cell_value[k+1];
            assign n_index = cell_index[k+1];
        end

        dsa_cell #(
            .VALUE_BITS (VALUE_BITS),
            .IDX_BITS   (IDX_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_value  (new_value),
            .new_index  (new_index),
            .prev_valid (p_valid),
            .prev_value (p_value),
            .prev_index (p_index),
            .prev_ins   (p_ins),
            .next_valid (n_valid),
            .next_value (n_value),
            .next_index (n_index),
            .valid      (cell_valid[k]),
            .value      (cell_value[k]),
            .index      (cell_index[k]),
            .ins        (cell_ins[k])
        );
    end

    // Results come straight from the head cell during the drain.
    assign result_valid    = busy;
    assign result.position = PB'(cell_index[0]) + PB'(1);
    assign result.last_out = last_result;
    assign result.overflow = overflow_reg;

    // Checks on the sequencer and chain.
    `DSA_ASSERT_NOW(a_head_valid, result_valid, cell_valid[0],
        "result strobe with an empty head cell")
    `DSA_ASSERT_NEXT(a_last_ends, result_valid && result.last_out, !busy,
        "drain continues after the final result")
    `DSA_ASSERT_NEXT(a_drain_runs, result_valid && !result.last_out, result_valid,
        "drain stopped before the final result")
    `DSA_ASSERT_NEXT(a_count_step, accept && !full && !item.last_in,
        count_reg == $past(count_reg) + CNT_BITS'(1),
        "load transfer did not advance the count")

endmodule

`default_nettype wire

// ===== tb/descending_argsort_checker.sv =====
// Checker that predicts and compares the ranked positions of the descending argsort.
`timescale 1ns / 1ps

module descending_argsort_checker #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire                 busy,
    input  dsa_pkg::in_item_t   item,
    input  wire                 result_valid,
    input  dsa_pkg::out_item_t  result,
    output int                  fail_count,
    output int                  pending
);

    // Values of the set being loaded, in load order.
    logic [VALUE_BITS-1:0] loaded_values [MAX_ITEMS];
    int                    loaded_count;
    bit                    values_dropped;

    // Ranked positions still to come out of the block, oldest first.
    dsa_pkg::out_item_t    expected_ranks [$];
    int                    mismatches;

    // Rank the loaded set from largest to smallest value. On equal values the later
    // load position wins, so the scan keeps the last candidate it sees among equals.
    task automatic rank_loaded_set();
        bit                 taken [MAX_ITEMS];
        int                 best;
        dsa_pkg::out_item_t rank_item;
        for (int k = 0; k < MAX_ITEMS; k++)
        begin
            taken[k] = 1'b0;
        end
        for (int r = 0; r < loaded_count; r++)
        begin
            best = -1;
            for (int k = 0; k < loaded_count; k++)
            begin
                if (!taken[k] && (best < 0 || loaded_values[k] >= loaded_values[best]))
                begin
                    best = k;
                end
            end
            taken[best]        = 1'b1;
            rank_item.position = dsa_pkg::POSITION_BITS'(best + 1);
            rank_item.last_out = (r == loaded_count - 1);
            rank_item.overflow = values_dropped;
            expected_ranks.push_back(rank_item);
        end
    endtask

    // Watch both channels on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        dsa_pkg::out_item_t oldest;
        if (!rst_n)
        begin
            loaded_count   = 0;
            values_dropped = 1'b0;
            mismatches     = 0;
            expected_ranks.delete();
            fail_count    <= 0;
            pending       <= 0;
        end
        else
        begin
            // Compare each result transfer with the oldest expectation.
            if (result_valid)
            begin
                if (expected_ranks.size() == 0)
                begin
                    $display("%0t: unexpected result, position %0d last %b overflow %b",
                             $time, result.position, result.last_out, result.overflow);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_ranks.pop_front();
                    if (result.position !== oldest.position)
                    begin
                        $display("%0t: position mismatch, expected %0d, actual %0d",
                                 $time, oldest.position, result.position);
                        mismatches++;
                    end
                    if (result.last_out !== oldest.last_out)
                    begin
                        $display("%0t: last_out mismatch, expected %b, actual %b",
                                 $time, oldest.last_out, result.last_out);
                        mismatches++;
                    end
                    if (result.overflow !== oldest.overflow)
                    begin
                        $display("%0t: overflow mismatch, expected %b, actual %b",
                                 $time, oldest.overflow, result.overflow);
                        mismatches++;
                    end
                end
            end

            // An input transfer loads a value, or is dropped once the store is full.
            if (start && !busy)
            begin
                if (loaded_count < MAX_ITEMS)
                begin
                    loaded_values[loaded_count] = VALUE_BITS'(item.value);
                    loaded_count++;
                end
                else
                begin
                    values_dropped = 1'b1;
                end
                if (item.last_in)
                begin
                    rank_loaded_set();
                    loaded_count   = 0;
                    values_dropped = 1'b0;
                end
            end

            fail_count <= mismatches;
            pending    <= expected_ranks.size();
        end
    end

endmodule

// ===== tb/descending_argsort_tb.sv =====
// Top of the descending argsort testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module descending_argsort_tb;

    localparam int MAX_ITEMS      = 64;
    localparam int VALUE_BITS     = 32;
    localparam int IDLE_PCT       = 14;
    localparam int ITEM_TARGET    = 350;
    localparam int DRAIN_MARGIN   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    dsa_pkg::in_item_t  item;
    logic               result_valid;
    dsa_pkg::out_item_t result;
    int                 fail_count;
    int                 pending;

    int        idle_pct;
    int        items_sent;
    int        set_index;
    int        set_size;
    int        quiet_cycles;

    descending_argsort #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    descending_argsort_checker #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // 2 ns clock.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Abort if no transfer on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            if ((start && !busy) || result_valid)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // Mix of full-range values, small values that tie often, and the extremes.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 7);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Offer one value, with random idle cycles first, and hold it until the transfer.
    task automatic offer_value(input logic [31:0] v, input logic closing);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            item  <= {$urandom(), 1'($urandom_range(0, 1))};
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= {v, closing};
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Load a whole set of random values, the last one closing it.
    task automatic offer_set(input int size);
        for (int k = 0; k < size; k++)
        begin
            offer_value(pick_value(), k == size - 1);
        end
    endtask

    // Hold off input until every expected ranked position has come out.
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        item         <= '0;
        idle_pct      = IDLE_PCT;
        items_sent    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-element sets at both extremes.
        offer_value(32'h0000_0000, 1'b1);
        offer_value(32'hFFFF_FFFF, 1'b1);

        // Extremes mixed with repeated values, so that ties are broken by position.
        offer_value(32'h0000_0005, 1'b0);
        offer_value(32'hFFFF_FFFF, 1'b0);
        offer_value(32'h0000_0005, 1'b0);
        offer_value(32'h0000_0000, 1'b0);
        offer_value(32'hFFFF_FFFF, 1'b0);
        offer_value(32'h8000_0000, 1'b0);
        offer_value(32'h7FFF_FFFF, 1'b0);
        offer_value(32'h0000_0005, 1'b1);

        // All values equal.
        offer_value(32'h0000_0009, 1'b0);
        offer_value(32'h0000_0009, 1'b0);
        offer_value(32'h0000_0009, 1'b1);

        // Ascending and descending load order.
        for (int k = 1; k <= 4; k++)
        begin
            offer_value(32'(k), k == 4);
        end
        for (int k = 4; k >= 1; k--)
        begin
            offer_value(32'(k), k == 1);
        end

        wait_for_drain();

        // Random sets: mostly small, with an exactly full set and two overflowing ones,
        // one where only the closing value is dropped and one where several are.
        set_index = 0;
        while (items_sent < ITEM_TARGET)
        begin
            idle_pct = (set_index >= 10 && set_index < 16) ? 0 : IDLE_PCT;
            case (set_index)
                1:       set_size = MAX_ITEMS;
                4:       set_size = MAX_ITEMS + 1;
                7:       set_size = MAX_ITEMS + 3;
                default: set_size = $urandom_range(1, 10);
            endcase
            offer_set(set_size);
            if ($urandom_range(0, 9) == 0)
            begin
                wait_for_drain();
            end
            set_index++;
        end

        // Let the last drain finish, then a few quiet cycles before the verdict.
        wait_for_drain();
        repeat (DRAIN_MARGIN) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== descending_argsort.f =====
+incdir+src
src/dsa_pkg.sv
src/dsa_cell.sv
src/descending_argsort.sv
tb/descending_argsort_checker.sv
tb/descending_argsort_tb.sv
